[rtl/core/lkvm_pkg.sv]
// ----------------------------------------------------------------------------
// lkvm_pkg
// Shared types and constants for the linear key-value map: field widths,
// request codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package lkvm_pkg;

    // field widths of the stream payload
    localparam int OP_W      = 2;
    localparam int KEY_W     = 16;
    localparam int VAL_W     = 16;
    localparam int CNT_OUT_W = 5;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    // request kinds
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic rd_cur;
        logic rd_next;
        logic idx_inc;
        logic set_hit;
        logic wr_shift;
        logic cnt_dec;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic idx_last;
        logic key_match;
        logic op_delete;
        logic out_free;
    } t_status;

endpackage

[rtl/core/lkvm_ram.sv]
// ----------------------------------------------------------------------------
// lkvm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lkvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/lkvm_ctrl.sv]
// ----------------------------------------------------------------------------
// lkvm_ctrl
// Request sequencer: accepts a request, walks the entries one at a time,
// shifts entries down on delete and hands the result to the output register.
// ----------------------------------------------------------------------------
module lkvm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  lkvm_pkg::t_status i_status,
    output lkvm_pkg::t_cmd    o_cmd
);

    import lkvm_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = i_status.count_zero ? ST_FINISH : ST_RD;
                end
            end
            ST_RD: begin
                o_cmd.rd_cur = 1'b1;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                priority if (i_status.key_match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state = i_status.op_delete ? ST_SH_RD : ST_FINISH;
                end else if (i_status.idx_last) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = ST_RD;
                end
            end
            ST_SH_RD: begin
                if (i_status.idx_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state = ST_SH_RD;
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/lkvm_dpath.sv]
// ----------------------------------------------------------------------------
// lkvm_dpath
// Entry storage, request and index registers, fill count, key compare and
// the result register.
// ----------------------------------------------------------------------------
module lkvm_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lkvm_pkg::t_cmd                 i_cmd,
    output lkvm_pkg::t_status              o_status,
    input  logic [lkvm_pkg::OP_W-1:0]      i_op,
    input  logic [lkvm_pkg::KEY_W-1:0]     i_key,
    input  logic [lkvm_pkg::VAL_W-1:0]     i_value,
    input  logic                           i_cfg_valid,
    input  logic [lkvm_pkg::VAL_W-1:0]     i_cfg_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [lkvm_pkg::OUT_DATA_W-1:0] o_out_data
);

    import lkvm_pkg::*;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WORD_W = KEY_W + VAL_W;
    localparam int PAD_W  = OUT_DATA_W - (1 + VAL_W + CNT_OUT_W + 3);

    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_count;
    logic [VAL_W-1:0] r_undef;
    logic             r_hit;
    logic [VAL_W-1:0] r_hit_val;
    logic             r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [WORD_W-1:0] rd_word;
    logic [KEY_W-1:0]  rd_key;
    logic [VAL_W-1:0]  rd_val;
    logic              full;
    logic              ins_ok;
    logic              rejected;
    logic [CNT_W-1:0]  count_after;
    logic [VAL_W-1:0]  value_out;
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic [IDX_W-1:0]  ram_rd_addr;
    logic [IDX_W-1:0]  idx_p1;

    assign rd_key = rd_word[KEY_W-1:0];
    assign rd_val = rd_word[WORD_W-1:KEY_W];
    assign idx_p1 = r_idx + 1'b1;
    assign full   = (r_count == CNT_W'(CAPACITY));

    // insert happens at the finish step when the key was absent and the table not full
    assign ins_ok      = (r_op == OP_INSERT) && !r_hit && !full;
    assign rejected    = (r_op == OP_INSERT) && !r_hit && full;
    assign count_after = ins_ok ? r_count + 1'b1 : r_count;
    assign value_out   = ((r_op == OP_LOOKUP) && r_hit) ? r_hit_val : r_undef;

    // status to the controller
    assign o_status.count_zero = (r_count == '0);
    assign o_status.idx_last   = ((CNT_W'(r_idx) + 1'b1) == r_count);
    assign o_status.key_match  = (rd_key == r_key);
    assign o_status.op_delete  = (r_op == OP_DELETE);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // entry store port muxing
    assign ram_wr_en   = i_cmd.wr_shift || (i_cmd.finish && ins_ok);
    assign ram_wr_addr = i_cmd.wr_shift ? r_idx : r_count[IDX_W-1:0];
    assign ram_wr_data = i_cmd.wr_shift ? rd_word : {r_value, r_key};
    assign ram_rd_addr = i_cmd.rd_next ? idx_p1 : r_idx;

    lkvm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (i_cmd.rd_cur || i_cmd.rd_next),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (rd_word)
    );

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    // scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= idx_p1;
        end
    end

    // hit flag and matched value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.load_req) begin
            r_hit <= 1'b0;
        end else if (i_cmd.set_hit) begin
            r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_hit) begin
            r_hit_val <= rd_val;
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - 1'b1;
        end else if (i_cmd.finish) begin
            r_count <= count_after;
        end
    end

    // miss value register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_undef <= '0;
        end else if (i_cfg_valid) begin
            r_undef <= i_cfg_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= {PAD_W'(0), rejected,
                           (count_after == CNT_W'(CAPACITY)),
                           (count_after == '0),
                           CNT_OUT_W'(count_after), value_out, r_hit};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[rtl/core/linear_key_value_map_top.sv]
// ----------------------------------------------------------------------------
// linear_key_value_map_top
// Fixed-capacity key-value table kept as a packed list with a fill count.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the kind (lookup,
//   insert, delete), tdata the key and the value. One result per request
//   leaves on the m_axis channel with the found flag, the looked-up value
//   (or the miss value), the count after the request and the empty, full
//   and rejected flags.
//   The miss value is written over the cfg channel; the user must write it
//   only while the block is idle, as the block does not enforce this.
//   One request is in work at a time. The entries sit in one RAM with a
//   registered read; the key scan visits the entries one at a time, and a
//   delete that hits moves each later entry down by a read and a write.
//   Reset empties the table and clears the miss value; no clearing pass.
//   A stalled receiver holds the result in the output register; the next
//   request is still accepted and worked on, and waits at its finish step
//   until the output register is free.
// ----------------------------------------------------------------------------
module linear_key_value_map_top #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key[15:0], value[31:16]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // found[0], value_out[16:1],
                                        // entry_count_out[21:17], is_empty[22],
                                        // is_full[23], rejected[24], zero[31:25]
    // miss value write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    import lkvm_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    lkvm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lkvm_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_op        (s_axis_tuser),
        .i_key       (s_axis_tdata[KEY_W-1:0]),
        .i_value     (s_axis_tdata[KEY_W+VAL_W-1:KEY_W]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

[tb/sv/linear_key_value_map_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_key_value_map_top_tb
// Self-checking bench for the fixed-capacity key-value table. A directed
// table walks the empty, full, duplicate, absent and unused-kind cases, then
// random phases with a small key pool alternate fill-heavy and drain-heavy
// request mixes under several miss values. Every result is checked against
// its directed row or a behavioral copy, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module linear_key_value_map_top_tb;
    import lkvm_pkg::*;

    localparam int CAPACITY       = 16;
    localparam int DIRECTED_ROWS  = 25;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 240;
    localparam int KEY_POOL       = 20;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_PAUSE    = 4;
    localparam int END_WAIT       = 40;
    // longest legal quiet stretch is the long receiver hold; random stalls
    // plus a worst-case request stay well below it
    localparam int WATCHDOG_LIMIT = 3000;

    // op 3 has no name in the package
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // one result, fields in the order they are read
    typedef struct packed {
        logic                 found;
        logic [VAL_W-1:0]     value_out;
        logic [CNT_OUT_W-1:0] count;
        logic                 is_empty;
        logic                 is_full;
        logic                 rejected;
    } t_map_result;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        bit               has_want;
        t_map_result      want;
    } t_directed_row;

    localparam t_map_result NO_WANT = '0;

    // dut ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // key[15:0], value[31:16]
    logic [OP_W-1:0]       s_axis_tuser = '0;   // op[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // found[0], value_out[16:1],
                                                // count[21:17], is_empty[22],
                                                // is_full[23], rejected[24]
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [VAL_W-1:0]      i_cfg_data = '0;

    // behavioral table
    logic [KEY_W-1:0] model_keys [CAPACITY];
    logic [VAL_W-1:0] model_values [CAPACITY];
    int               model_count = 0;
    logic [VAL_W-1:0] miss_value = '0;

    t_map_result pending_results [$];

    // pacing controls
    bit tx_random = 1'b1;
    bit rx_random = 1'b1;
    bit hold_toggle = 1'b0;
    bit hold_seen = 1'b0;
    int rx_stall_left = 0;
    int idle_cycles = 0;

    // run statistics
    int n_errors = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_hits = 0;
    int n_rejected = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_cfg_writes = 0;

    // directed cases; the miss value is still at its reset value of zero
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        // empty table: miss, absent delete, unused kind
        '{OP_LOOKUP, 16'h0000, 16'h0000, 1'b1, '{1'b0, 16'h0000, 5'd0, 1'b1, 1'b0, 1'b0}},
        '{OP_DELETE, 16'hFFFF, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, 5'd0, 1'b1, 1'b0, 1'b0}},
        '{OP_UNUSED, 16'h5A5A, 16'hA5A5, 1'b1, '{1'b0, 16'h0000, 5'd0, 1'b1, 1'b0, 1'b0}},
        // fill to capacity
        '{OP_INSERT, 16'h0000, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, 5'd1, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'hFFFF, 16'h0000, 1'b1, '{1'b0, 16'h0000, 5'd2, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0001, 16'hFFFE, 1'b1, '{1'b0, 16'h0000, 5'd3, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0002, 16'hFFFD, 1'b1, '{1'b0, 16'h0000, 5'd4, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0004, 16'hFFFB, 1'b1, '{1'b0, 16'h0000, 5'd5, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0008, 16'hFFF7, 1'b1, '{1'b0, 16'h0000, 5'd6, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0010, 16'hFFEF, 1'b1, '{1'b0, 16'h0000, 5'd7, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0020, 16'hFFDF, 1'b1, '{1'b0, 16'h0000, 5'd8, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0040, 16'hFFBF, 1'b1, '{1'b0, 16'h0000, 5'd9, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0080, 16'hFF7F, 1'b1, '{1'b0, 16'h0000, 5'd10, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0100, 16'hFEFF, 1'b1, '{1'b0, 16'h0000, 5'd11, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0200, 16'hFDFF, 1'b1, '{1'b0, 16'h0000, 5'd12, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0400, 16'hFBFF, 1'b1, '{1'b0, 16'h0000, 5'd13, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h0800, 16'hF7FF, 1'b1, '{1'b0, 16'h0000, 5'd14, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h1000, 16'hEFFF, 1'b1, '{1'b0, 16'h0000, 5'd15, 1'b0, 1'b0, 1'b0}},
        '{OP_INSERT, 16'h2000, 16'hDFFF, 1'b1, '{1'b0, 16'h0000, 5'd16, 1'b0, 1'b1, 1'b0}},
        // new key into a full table is refused
        '{OP_INSERT, 16'h7777, 16'h1111, 1'b1, '{1'b0, 16'h0000, 5'd16, 1'b0, 1'b1, 1'b1}},
        // present key keeps its old value, no refusal
        '{OP_INSERT, 16'hFFFF, 16'h1234, 1'b1, '{1'b1, 16'h0000, 5'd16, 1'b0, 1'b1, 1'b0}},
        '{OP_LOOKUP, 16'hFFFF, 16'hFFFF, 1'b1, '{1'b1, 16'h0000, 5'd16, 1'b0, 1'b1, 1'b0}},
        // delete of the first entry shifts the whole table
        '{OP_DELETE, 16'h0000, 16'h0000, 1'b1, '{1'b1, 16'h0000, 5'd15, 1'b0, 1'b0, 1'b0}},
        '{OP_LOOKUP, 16'h0001, 16'h0000, 1'b0, NO_WANT},
        '{OP_UNUSED, 16'h2000, 16'hFFFF, 1'b0, NO_WANT}
    };

    // miss values per phase, extremes first; phases 2 and 5 draw a random one
    logic [VAL_W-1:0] miss_plan [PHASES] = '{
        16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 16'h0001, 16'h0000, 16'h7FFE, 16'hFFFF
    };

    linear_key_value_map_top #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stall length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // apply one request to the behavioral table and return its result
    function automatic t_map_result kv_apply_request(input logic [OP_W-1:0] op,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [VAL_W-1:0] value);
        t_map_result res;
        int          slot;
        int          i;
        bit          hit;
        slot = model_count;
        for (i = 0; i < model_count; i++) begin
            if (model_keys[i] == key) begin
                slot = i;
                break;
            end
        end
        hit = (slot < model_count);
        res = '0;
        res.value_out = miss_value;
        case (op)
            OP_LOOKUP: begin
                if (hit)
                    res.value_out = model_values[slot];
            end
            OP_INSERT: begin
                if (!hit) begin
                    if (model_count >= CAPACITY) begin
                        res.rejected = 1'b1;
                    end else begin
                        model_keys[model_count]   = key;
                        model_values[model_count] = value;
                        model_count++;
                    end
                end
            end
            OP_DELETE: begin
                if (hit) begin
                    for (i = slot + 1; i < model_count; i++) begin
                        model_keys[i-1]   = model_keys[i];
                        model_values[i-1] = model_values[i];
                    end
                    model_count--;
                end
            end
            default: ;
        endcase
        res.found    = hit;
        res.count    = CNT_OUT_W'(model_count);
        res.is_empty = (model_count == 0);
        res.is_full  = (model_count == CAPACITY);
        n_hits     += hit;
        n_rejected += res.rejected;
        n_full     += res.is_full;
        n_empty    += res.is_empty;
        return res;
    endfunction

    // offer one request, wait for it to be taken, then maybe leave a gap
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value, input bit has_want,
                                input t_map_result want);
        t_map_result predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = kv_apply_request(op, key, value);
        pending_results.push_back(has_want ? want : predicted);
        n_requests++;
        if (tx_random && $urandom_range(0, 99) < 40) begin
            s_axis_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_miss_value(input logic [VAL_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        miss_value = v;
        n_cfg_writes++;
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            n_errors++;
        end
    endtask

    // receiver: random ready, plus one long hold on request
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen     <= hold_toggle;
            rx_stall_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!rx_random || $urandom_range(0, 99) < 70) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= pick_gap() - 1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_map_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result 0x%0h with no request outstanding", m_axis_tdata);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                compare_field("found", want.found, m_axis_tdata[0]);
                compare_field("value_out", want.value_out, m_axis_tdata[16:1]);
                compare_field("entry_count_out", want.count, m_axis_tdata[21:17]);
                compare_field("is_empty", want.is_empty, m_axis_tdata[22]);
                compare_field("is_full", want.is_full, m_axis_tdata[23]);
                compare_field("rejected", want.rejected, m_axis_tdata[24]);
                compare_field("pad", 0, m_axis_tdata[31:25]);
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("linear_key_value_map_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        logic [KEY_W-1:0] key_pool [KEY_POOL];
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        int               ins_pct;
        int               del_pct;
        int               r;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            send_request(directed_rows[row].op, directed_rows[row].key,
                         directed_rows[row].value, directed_rows[row].has_want,
                         directed_rows[row].want);
        end

        // random phases, alternating fill-heavy and drain-heavy mixes
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            if (phase == 2 || phase == 5)
                write_miss_value(VAL_W'($urandom_range(0, 65535)));
            else
                write_miss_value(miss_plan[phase]);
            tx_random = (phase != 3);
            rx_random = (phase != 3);
            ins_pct   = (phase % 2 == 0) ? 60 : 25;
            del_pct   = (phase % 2 == 0) ? 15 : 50;
            // pool a bit larger than capacity so both hits and full tables occur
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int k = 2; k < KEY_POOL; k++)
                key_pool[k] = KEY_W'($urandom_range(0, 65535));

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold while requests keep coming
                if (phase == 2 && n == 40)
                    hold_toggle <= ~hold_toggle;
                r = $urandom_range(0, 99);
                if (r < 3)
                    op = OP_UNUSED;
                else if (r < 3 + ins_pct)
                    op = OP_INSERT;
                else if (r < 3 + ins_pct + del_pct)
                    op = OP_DELETE;
                else
                    op = OP_LOOKUP;
                if ($urandom_range(0, 9) == 0)
                    key = KEY_W'($urandom_range(0, 65535));
                else
                    key = key_pool[$urandom_range(0, KEY_POOL - 1)];
                r = $urandom_range(0, 9);
                if (r == 0)
                    value = '0;
                else if (r == 1)
                    value = '1;
                else
                    value = VAL_W'($urandom_range(0, 65535));
                send_request(op, key, value, 1'b0, NO_WANT);
            end
        end

        wait_drained();
        repeat (END_WAIT) @(posedge i_clk);

        $display("covered %0d requests, %0d results: %0d hits, %0d refused inserts",
                 n_requests, n_results, n_hits, n_rejected);
        $display("table full after %0d requests, empty after %0d, %0d miss value writes",
                 n_full, n_empty, n_cfg_writes);
        if (n_errors == 0)
            $display("linear_key_value_map_top regression: pass");
        else
            $display("linear_key_value_map_top regression: fail");
        $finish;
    end

endmodule
